>>> sv/assert_macros.svh
// Assertion helpers for the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define OFP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OFP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ofp_pkg.sv
package ofp_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int E_W        = 32;           // matrix entry, Q2.30
  localparam int SC_W       = 30;           // block-scaled magnitude bits
  localparam int SC_TOP     = SC_W - 1;     // leading one lands here
  localparam int SQ_W       = 62;           // sum of three squares
  localparam int ROOT_W     = 31;
  localparam int NUM_W      = 61;           // (m << 30) + r/2
  localparam int Q_W        = 31;
  localparam int D_MAG_W    = 34;           // remainder vector magnitude
  localparam int BSCALE_LAT = 3;
  localparam int UNIT_LAT   = BSCALE_LAT + 2 + ROOT_W + Q_W + 1;
  localparam int OUT_TD_W   = 9 * E_W;

  localparam logic signed [E_W-1:0] ONE_Q30 = 32'sh4000_0000;

  typedef logic signed [E_W-1:0] ent_t;

  typedef struct packed {
    logic ok;
    ent_t x;
    ent_t y;
    ent_t z;
  } uvec_t;

  // divide by 2^30, round half away from zero
  function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? $unsigned(-v) : $unsigned(v);
    m = (m + (64'd1 << 29)) >> 30;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic ent_t clamp1(input logic signed [63:0] v);
    if (v > 64'sd1073741824) begin
      return ONE_Q30;
    end else if (v < -64'sd1073741824) begin
      return -ONE_Q30;
    end else begin
      return $signed(v[E_W-1:0]);
    end
  endfunction

endpackage

>>> sv/ofp_delay.sv
module ofp_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < DEPTH; i++) taps[i] <= taps[i-1];
    end
  end

  assign q = taps[DEPTH-1];

endmodule

>>> sv/ofp_bscale.sv
// Block scaling: largest magnitude's top bit moved to bit 29. Three stages.
module ofp_bscale import ofp_pkg::*; #(
  parameter int MAGW = 32
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [2:0][MAGW-1:0]       mag,
  input  logic [2:0]                 neg,
  output logic [2:0][SC_W-1:0]       vmag,
  output logic [2:0]                 vneg,
  output logic                       ok
);

  localparam int TW = $clog2(MAGW);

  logic [2:0][MAGW-1:0] mag1, mag2;
  logic [2:0]           neg1, neg2;
  logic [MAGW-1:0]      m01, mx_c, mx1;
  logic [TW-1:0]        t_c, t2;
  logic                 ok2;

  assign m01  = (mag[0] > mag[1]) ? mag[0] : mag[1];
  assign mx_c = (m01 > mag[2]) ? m01 : mag[2];

  always_comb begin
    t_c = '0;
    for (int i = 0; i < MAGW; i++) begin
      if (mx1[i]) t_c = TW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1 <= mag;
      neg1 <= neg;
      mx1  <= mx_c;
      mag2 <= mag1;
      neg2 <= neg1;
      t2   <= t_c;
      ok2  <= |mx1;
      vneg <= neg2;
      ok   <= ok2;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_sh
    logic [MAGW+SC_TOP-1:0] wide;
    // (mag << 29) >> t: left or right shift in one step, truncating
    assign wide = {mag2[i], {SC_TOP{1'b0}}} >> t2;
    always_ff @(posedge clk) begin
      if (en) vmag[i] <= wide[SC_W-1:0];
    end
  end

endmodule

>>> sv/ofp_isqrt.sv
// Digit-by-digit integer square root, one result bit per stage.
module ofp_isqrt import ofp_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SQ_W-1:0]   s,
  output logic [ROOT_W-1:0] r
);

  logic [SQ_W:0] s_st [ROOT_W];
  logic [SQ_W:0] r_st [ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_st
    localparam logic [SQ_W:0] BIT = (SQ_W+1)'(1) << (2 * (ROOT_W - 1 - g));
    logic [SQ_W:0] s_in, r_in, trial;
    if (g == 0) begin : g_first
      assign s_in = {1'b0, s};
      assign r_in = '0;
    end else begin : g_next
      assign s_in = s_st[g-1];
      assign r_in = r_st[g-1];
    end
    assign trial = r_in + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (s_in >= trial) begin
          s_st[g] <= s_in - trial;
          r_st[g] <= (r_in >> 1) + BIT;
        end else begin
          s_st[g] <= s_in;
          r_st[g] <= r_in >> 1;
        end
      end
    end
  end

  assign r = r_st[ROOT_W-1][ROOT_W-1:0];

endmodule

>>> sv/ofp_div.sv
// Restoring divider, one quotient bit per stage, MSB first.
module ofp_div import ofp_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num,
  input  logic [ROOT_W-1:0] den,
  output logic [Q_W-1:0]    q
);

  localparam int RW = NUM_W + 1;

  logic [RW-1:0]     rem_st [Q_W];
  logic [ROOT_W-1:0] den_st [Q_W];
  logic [Q_W-1:0]    q_st   [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_st
    localparam int K = Q_W - 1 - j;
    logic [RW-1:0]     rem_in, dsh;
    logic [ROOT_W-1:0] den_in;
    logic [Q_W-1:0]    q_in;
    if (j == 0) begin : g_first
      assign rem_in = RW'(num);
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_st[j-1];
      assign den_in = den_st[j-1];
      assign q_in   = q_st[j-1];
    end
    assign dsh = RW'(den_in) << K;
    always_ff @(posedge clk) begin
      if (en) begin
        den_st[j] <= den_in;
        if (rem_in >= dsh) begin
          rem_st[j] <= rem_in - dsh;
          q_st[j]   <= q_in | (Q_W'(1) << K);
        end else begin
          rem_st[j] <= rem_in;
          q_st[j]   <= q_in;
        end
      end
    end
  end

  assign q = q_st[Q_W-1];

endmodule

>>> sv/ofp_unit.sv
// Normalize a sign/magnitude vector to a Q2.30 unit vector. UNIT_LAT stages.
module ofp_unit import ofp_pkg::*; #(
  parameter int MAGW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [2:0][MAGW-1:0] mag,
  input  logic [2:0]           neg,
  output uvec_t                e
);

  localparam int SIDE_W = 3 * SC_W + 4;

  logic [2:0][SC_W-1:0] vmag, vmag_r;
  logic [2:0]           vneg, vneg_r, vneg_q;
  logic                 vok, vok_r, vok_q;
  logic [2*SC_W-1:0]    sq [3];
  logic [SQ_W-1:0]      sum;
  logic [ROOT_W-1:0]    root;
  logic [Q_W-1:0]       q [3];
  ent_t                 ev [3];

  ofp_bscale #(.MAGW(MAGW)) u_bscale (
    .clk, .en, .mag, .neg, .vmag, .vneg, .ok(vok)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq[i] <= vmag[i] * vmag[i];
      sum <= SQ_W'(sq[0]) + SQ_W'(sq[1]) + SQ_W'(sq[2]);
    end
  end

  ofp_isqrt u_isqrt (.clk, .en, .s(sum), .r(root));

  // operands wait out the squares and the root
  ofp_delay #(.WIDTH(SIDE_W), .DEPTH(2 + ROOT_W)) u_side (
    .clk, .en, .d({vmag, vneg, vok}), .q({vmag_r, vneg_r, vok_r})
  );

  ofp_delay #(.WIDTH(4), .DEPTH(Q_W)) u_sign (
    .clk, .en, .d({vneg_r, vok_r}), .q({vneg_q, vok_q})
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic [NUM_W-1:0] num;
    logic [Q_W-1:0]   qc;
    ent_t             qs;
    assign num = NUM_W'({vmag_r[i], {SC_W{1'b0}}}) + NUM_W'(root >> 1);
    ofp_div u_div (.clk, .en, .num, .den(root), .q(q[i]));
    assign qc = (q[i] > Q_W'(ONE_Q30)) ? Q_W'(ONE_Q30) : q[i];
    assign qs = ent_t'(qc);
    always_ff @(posedge clk) begin
      if (en) ev[i] <= vneg_q[i] ? -qs : qs;
    end
  end

  logic ok_f;
  always_ff @(posedge clk) begin
    if (en) ok_f <= vok_q;
  end

  assign e = '{ok: ok_f, x: ev[0], y: ev[1], z: ev[2]};

endmodule

>>> sv/ofp_out_buf.sv
// Two-entry result buffer between the pipeline and the output port.
module ofp_out_buf #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  output logic             valid,
  input  logic             ready,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count, count_next;
  logic             pop;

  assign pop   = valid && ready;
  assign valid = count != 2'd0;
  assign full  = count == 2'd2;
  assign dout  = slot[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + 2'd1;
    else if (pop && !push) count_next = count - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= din;
  end

endmodule

>>> sv/orthonormal_frame_from_points_core.sv
// Two normalizers of 68 stages each (31-stage square root, 31-stage divider) plus projection,
// cross product and buffer stages lie between an input request and its result.
// Throughput: one request per cycle; a 2-entry output buffer lets the pipe run
// while results wait, and the whole pipe holds only when that buffer is full.
// Reset (rst, synchronous) clears the valid bits and the output buffer.
`include "assert_macros.svh"
module orthonormal_frame_from_points_core import ofp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int IN_W = ((12 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // p0_x p0_y p0_z p1_x p1_y p1_z p2_x p2_y p2_z p3_x p3_y p3_z, zero pad
  input  logic [IN_W-1:0]     s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // e1_x e2_x e3_x e1_y e2_y e3_y e1_z e2_z e3_z
  output logic [OUT_TD_W-1:0] m_tdata,
  // degenerate
  output logic                m_tuser
);

  localparam int W         = COORD_WIDTH;
  localparam int BN_W      = SC_W + 1;
  localparam int TOTAL_LAT = 1 + UNIT_LAT + 5 + UNIT_LAT + 3;

  logic en, full;
  logic [TOTAL_LAT-1:0] vld;

  assign en       = !full;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[TOTAL_LAT-2:0], s_tvalid};
  end

  // axis differences, sign and magnitude
  logic [2:0][W-1:0] amag, bmag;
  logic [2:0]        aneg, bneg;

  for (genvar i = 0; i < 3; i++) begin : g_diff
    logic signed [W:0] da, db;
    logic [W:0]        nda, ndb;
    assign da  = $signed({s_tdata[(3+i)*W+W-1], s_tdata[(3+i)*W +: W]})
               - $signed({s_tdata[i*W+W-1], s_tdata[i*W +: W]});
    assign db  = $signed({s_tdata[(9+i)*W+W-1], s_tdata[(9+i)*W +: W]})
               - $signed({s_tdata[(6+i)*W+W-1], s_tdata[(6+i)*W +: W]});
    assign nda = -da;
    assign ndb = -db;
    always_ff @(posedge clk) begin
      if (en) begin
        aneg[i] <= da[W];
        bneg[i] <= db[W];
        amag[i] <= da[W] ? nda[W-1:0] : da[W-1:0];
        bmag[i] <= db[W] ? ndb[W-1:0] : db[W-1:0];
      end
    end
  end

  uvec_t e1, e2;

  ofp_unit #(.MAGW(W)) u_e1 (.clk, .en, .mag(amag), .neg(aneg), .e(e1));

  logic [2:0][SC_W-1:0] bv_mag;
  logic [2:0]           bv_neg;
  logic                 b_ok, bok69;
  logic [2:0][BN_W-1:0] bn_c, bn69, bn73;

  ofp_bscale #(.MAGW(W)) u_bscale (
    .clk, .en, .mag(bmag), .neg(bneg), .vmag(bv_mag), .vneg(bv_neg), .ok(b_ok)
  );

  for (genvar i = 0; i < 3; i++) begin : g_bn
    assign bn_c[i] = bv_neg[i] ? -{1'b0, bv_mag[i]} : {1'b0, bv_mag[i]};
  end

  ofp_delay #(.WIDTH(3 * BN_W + 1), .DEPTH(UNIT_LAT - BSCALE_LAT)) u_bn_dly (
    .clk, .en, .d({bn_c, b_ok}), .q({bn69, bok69})
  );

  ofp_delay #(.WIDTH(3 * BN_W), .DEPTH(4)) u_bn_dly2 (
    .clk, .en, .d(bn69), .q(bn73)
  );

  ent_t e1a [3];
  assign e1a[0] = e1.x;
  assign e1a[1] = e1.y;
  assign e1a[2] = e1.z;

  logic [3*E_W-1:0] e1_72;
  ofp_delay #(.WIDTH(3 * E_W), .DEPTH(3)) u_e1_dly (
    .clk, .en, .d({e1.x, e1.y, e1.z}), .q(e1_72)
  );

  // projection of bn on e1, removed from bn
  logic signed [63:0] prod1 [3];
  logic signed [63:0] prod2 [3];
  logic signed [63:0] dot, dq_full;
  logic signed [32:0] dq;
  logic [2:0][D_MAG_W-1:0] dmag;
  logic [2:0]              dneg;

  assign dq_full = rnd30(dot);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) prod1[i] <= $signed(bn69[i]) * e1a[i];
      dot <= prod1[0] + prod1[1] + prod1[2];
      dq  <= dq_full[32:0];
      prod2[0] <= dq * $signed(e1_72[3*E_W-1 -: E_W]);
      prod2[1] <= dq * $signed(e1_72[2*E_W-1 -: E_W]);
      prod2[2] <= dq * $signed(e1_72[E_W-1 -: E_W]);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_rem
    logic signed [63:0] pr;
    logic signed [34:0] ds, nds;
    assign pr  = rnd30(prod2[i]);
    assign ds  = $signed({{4{bn73[i][BN_W-1]}}, bn73[i]}) - $signed(pr[34:0]);
    assign nds = -ds;
    always_ff @(posedge clk) begin
      if (en) begin
        dneg[i] <= ds[34];
        dmag[i] <= ds[34] ? nds[D_MAG_W-1:0] : ds[D_MAG_W-1:0];
      end
    end
  end

  ofp_unit #(.MAGW(D_MAG_W)) u_e2 (.clk, .en, .mag(dmag), .neg(dneg), .e(e2));

  logic [3*E_W-1:0] e1_142;
  logic             okab_142;
  ofp_delay #(.WIDTH(3 * E_W + 1), .DEPTH(5 + UNIT_LAT)) u_e1_dly2 (
    .clk, .en, .d({e1.x, e1.y, e1.z, e1.ok && bok69}), .q({e1_142, okab_142})
  );

  // cross product e3 = e1 x e2
  ent_t ax, ay, az, c1x [3], c1y [3], c2x [3], c2y [3];
  assign ax = $signed(e1_142[3*E_W-1 -: E_W]);
  assign ay = $signed(e1_142[2*E_W-1 -: E_W]);
  assign az = $signed(e1_142[E_W-1 -: E_W]);

  logic signed [63:0] cp [6];
  logic signed [63:0] cd [3];
  logic               ok_c1, ok_c2;

  always_ff @(posedge clk) begin
    if (en) begin
      cp[0] <= ay * e2.z;
      cp[1] <= az * e2.y;
      cp[2] <= az * e2.x;
      cp[3] <= ax * e2.z;
      cp[4] <= ax * e2.y;
      cp[5] <= ay * e2.x;
      c1x   <= '{ax, ay, az};
      c1y   <= '{e2.x, e2.y, e2.z};
      ok_c1 <= okab_142 && e2.ok;
      for (int i = 0; i < 3; i++) cd[i] <= cp[2*i] - cp[2*i+1];
      c2x   <= c1x;
      c2y   <= c1y;
      ok_c2 <= ok_c1;
    end
  end

  ent_t e3 [3];
  for (genvar i = 0; i < 3; i++) begin : g_e3
    assign e3[i] = clamp1(rnd30(cd[i]));
  end

  logic [OUT_TD_W-1:0] res_data;
  logic                res_user;

  always_ff @(posedge clk) begin
    if (en) begin
      res_user <= !ok_c2;
      if (ok_c2) begin
        res_data <= {e3[2], c2y[2], c2x[2], e3[1], c2y[1], c2x[1],
                     e3[0], c2y[0], c2x[0]};
      end else begin
        res_data <= '0;
      end
    end
  end

  ofp_out_buf #(.WIDTH(OUT_TD_W + 1)) u_out_buf (
    .clk,
    .rst,
    .push  (vld[TOTAL_LAT-1] && en),
    .din   ({res_user, res_data}),
    .full,
    .valid (m_tvalid),
    .ready (m_tready),
    .dout  ({m_tuser, m_tdata})
  );

  `OFP_ASSERT_IMP(a_degen_zero, clk, rst, m_tvalid && m_tuser, m_tdata == '0, "degenerate result with nonzero matrix")
  `OFP_ASSERT_IMP(a_stall_has_result, clk, rst, !s_tready, m_tvalid, "input stalled with no result pending")
  `OFP_ASSERT_NXT(a_full_holds, clk, rst, !s_tready && !m_tready, !s_tready, "buffer lost a result while stalled")
  `OFP_ASSERT_IMP(a_e1x_range, clk, rst, m_tvalid, ($signed(m_tdata[E_W-1:0]) <= ONE_Q30) && ($signed(m_tdata[E_W-1:0]) >= -ONE_Q30), "e1_x out of range")

endmodule

>>> tb/testbench.sv
module testbench;
  import ofp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_BITS = 12 * 32;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [OUT_TD_W-1:0] mat;
    logic degen;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_BITS-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TD_W-1:0] m_tdata;
  logic m_tuser;

  frame_t frames_pending[$];
  int errors = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_cycle = 0;
  int stall_mode = 0;

  orthonormal_frame_from_points_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- frame predictor ----------------
  function automatic longint round30(input longint v);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : longint'(v);
    m = (m + (64'd1 << 29)) >> 30;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint sat_one(input longint v);
    if (v > (64'sd1 << 30)) return 64'sd1 << 30;
    if (v < -(64'sd1 << 30)) return -(64'sd1 << 30);
    return v;
  endfunction

  function automatic bit scale_vec(input logic [2:0] n, input logic [2:0][63:0] mag,
                                   output logic [2:0][63:0] v);
    logic [63:0] mx;
    logic [63:0] m;
    int t;
    mx = mag[0];
    t = 0;
    v = '0;
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
    if (mx == 0) return 1'b0;
    while (t < 63 && (mx >> (t + 1)) != 0) t++;
    for (int i = 0; i < 3; i++) begin
      m = (t > 29) ? (mag[i] >> (t - 29)) : (mag[i] << (29 - t));
      v[i] = n[i] ? -m : m;
    end
    return 1'b1;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] s);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit normalize(input logic [2:0] n, input logic [2:0][63:0] mag,
                                   output logic [2:0][63:0] e);
    logic [2:0][63:0] v;
    logic [63:0] s;
    logic [63:0] r;
    logic [63:0] m;
    longint c;
    e = '0;
    s = 0;
    if (!scale_vec(n, mag, v)) return 1'b0;
    for (int i = 0; i < 3; i++) s = s + v[i] * v[i];
    r = int_sqrt(s);
    if (r == 0) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      c = longint'(v[i]);
      m = (c < 0) ? -c : c;
      m = ((m << 30) + (r >> 1)) / r;
      e[i] = sat_one((c < 0) ? -longint'(m) : longint'(m));
    end
    return 1'b1;
  endfunction

  function automatic frame_t predict_frame(input logic [IN_BITS-1:0] d);
    logic [2:0] an, bng, dn;
    logic [2:0][63:0] am, bm, dm, e1v, e2v, bnv;
    longint e1[3], e2[3], e3[3], bn[3];
    longint hi, lo, diff, dot, dq;
    bit ok;
    frame_t f;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      hi = longint'($signed(d[(3 + i) * 32 +: 32]));
      lo = longint'($signed(d[i * 32 +: 32]));
      diff = hi - lo;
      an[i] = diff < 0;
      am[i] = an[i] ? -diff : diff;
      hi = longint'($signed(d[(9 + i) * 32 +: 32]));
      lo = longint'($signed(d[(6 + i) * 32 +: 32]));
      diff = hi - lo;
      bng[i] = diff < 0;
      bm[i] = bng[i] ? -diff : diff;
    end
    f = '0;
    ok = normalize(an, am, e1v);
    if (ok) ok = scale_vec(bng, bm, bnv);
    if (ok) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] = longint'(e1v[i]);
        bn[i] = longint'(bnv[i]);
        dot += bn[i] * e1[i];
      end
      dq = round30(dot);
      for (int i = 0; i < 3; i++) begin
        diff = bn[i] - round30(dq * e1[i]);
        dn[i] = diff < 0;
        dm[i] = dn[i] ? -diff : diff;
      end
      ok = normalize(dn, dm, e2v);
    end
    if (!ok) begin
      f.degen = 1'b1;
      return f;
    end
    for (int i = 0; i < 3; i++) e2[i] = longint'(e2v[i]);
    e3[0] = sat_one(round30(e1[1] * e2[2] - e1[2] * e2[1]));
    e3[1] = sat_one(round30(e1[2] * e2[0] - e1[0] * e2[2]));
    e3[2] = sat_one(round30(e1[0] * e2[1] - e1[1] * e2[0]));
    for (int i = 0; i < 3; i++) begin
      f.mat[(i * 3 + 0) * 32 +: 32] = e1[i][31:0];
      f.mat[(i * 3 + 1) * 32 +: 32] = e2[i][31:0];
      f.mat[(i * 3 + 2) * 32 +: 32] = e3[i][31:0];
    end
    return f;
  endfunction

  // ---------------- request side ----------------
  task automatic send_points(input logic [11:0][31:0] p);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= p;
    do @(posedge clk); while (!s_tready);
  endtask

  // a = p1 - p0, b = p3 - p2; p0 is the given origin, p2 the same origin with its coordinates rotated
  task automatic send_axes(input logic [31:0] ox, oy, oz,
                           input longint ax, ay, az, bx, by, bz);
    logic [11:0][31:0] p;
    p[0] = ox; p[1] = oy; p[2] = oz;
    p[3] = ox + ax[31:0]; p[4] = oy + ay[31:0]; p[5] = oz + az[31:0];
    p[6] = oz; p[7] = ox; p[8] = oy;
    p[9] = oz + bx[31:0]; p[10] = ox + by[31:0]; p[11] = oy + bz[31:0];
    send_points(p);
  endtask

  function automatic logic [11:0][31:0] random_points();
    logic [11:0][31:0] p;
    for (int k = 0; k < 12; k++) p[k] = $urandom;
    return p;
  endfunction

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) frames_pending.push_back(predict_frame(s_tdata));
  end

  // ---------------- result side ----------------
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 97 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= $urandom_range(0, 1);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (stall_cycle % 32) < 20;
    endcase
  end

  task automatic report(input string what, input logic [31:0] got, want);
    $display("error %0t: %s got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    frame_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (frames_pending.size() == 0) begin
        report("unexpected result", m_tdata[31:0], 32'h0);
      end else begin
        want = frames_pending.pop_front();
        for (int k = 0; k < 9; k++)
          if (m_tdata[k * 32 +: 32] !== want.mat[k * 32 +: 32])
            report($sformatf("matrix entry %0d", k), m_tdata[k * 32 +: 32],
                   want.mat[k * 32 +: 32]);
        if (m_tuser !== want.degen)
          report("degenerate", 32'(m_tuser), 32'(want.degen));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("orthonormal_frame_from_points_core: mismatch");
        $finish;
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_degenerate();
    send_axes(0, 0, 0, 0, 0, 0, 5, 6, 7);               // zero first axis
    send_axes(32'h1234, 32'hffff0000, 7, 3, -4, 5, 0, 0, 0);  // zero second axis
    send_axes(0, 0, 0, 1, 2, 3, 2, 4, 6);               // parallel
    send_axes(9, 9, 9, 1, 2, 3, -3, -6, -9);            // anti-parallel
    send_axes(0, 0, 0, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_extremes();
    logic [11:0][31:0] p;
    for (int k = 0; k < 12; k++) p[k] = (k % 6 < 3) ? 32'h8000_0000 : 32'h7fff_ffff;
    send_points(p);
    for (int k = 0; k < 12; k++) p[k] = (k % 6 < 3) ? 32'h7fff_ffff : 32'h8000_0000;
    send_points(p);
    for (int k = 0; k < 12; k++) p[k] = k[0] ? 32'h7fff_ffff : 32'h8000_0000;
    send_points(p);
    send_axes(0, 0, 0, 1, 0, 0, 0, 1, 0);               // one lsb axes
    send_axes(0, 0, 0, 0, 0, 1, 1, 0, 0);
    send_axes(32'hffff_ffff, 0, 1, 65536, 0, 0, 0, 0, -65536);
    send_axes(0, 0, 0, 1, 1, 1, 1, 1, 0);
  endtask

  task automatic test_near_parallel();
    send_axes(0, 0, 0, 32'h4000_0000, 32'h3000_0000, 32'h2000_0000,
              32'h4000_0000, 32'h3000_0000, 32'h2000_0001);
    send_axes(0, 0, 0, 1000, 2000, 3000, 1000, 2000, 3001);
    send_axes(0, 0, 0, 32'h7fff_0000, 1, 0, 32'h7fff_0000, 0, 1);
    send_axes(0, 0, 0, 3, 0, 0, 7, 0, 1);
  endtask

  task automatic test_random(input int count);
    logic [11:0][31:0] p;
    longint ax, ay, az, bx, by, bz, k;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_points(random_points());
        3, 4: begin
          for (int j = 0; j < 12; j++) p[j] = $urandom_range(0, 4000) - 2000;
          send_points(p);
        end
        5: begin
          ax = $urandom_range(0, 200) - 100; ay = $urandom_range(0, 200) - 100;
          az = $urandom_range(0, 200) - 100; k = $urandom_range(1, 50) - 25;
          send_axes($urandom, $urandom, $urandom, ax, ay, az, k * ax, k * ay, k * az);
        end
        6: begin
          ax = $urandom_range(0, 32'h7fff_ffff); ay = $urandom_range(0, 32'h0fff_ffff);
          az = $urandom_range(0, 1000);
          bx = ax + $urandom_range(0, 4) - 2; by = ay + $urandom_range(0, 4) - 2;
          bz = az + $urandom_range(0, 4) - 2;
          send_axes(0, 0, 0, ax, ay, az, bx, by, bz);
        end
        7: begin
          p = random_points();
          p[3] = p[0]; p[4] = p[1]; p[5] = p[2];
          send_points(p);
        end
        8: begin
          p = random_points();
          p[9] = p[6]; p[10] = p[7]; p[11] = p[8];
          send_points(p);
        end
        default: begin
          ax = $urandom_range(0, 3) - 1; ay = $urandom_range(0, 3) - 1;
          az = $urandom_range(0, 3) - 1; bx = $urandom_range(0, 3) - 1;
          by = $urandom_range(0, 3) - 1; bz = $urandom_range(0, 3) - 1;
          send_axes($urandom, $urandom, $urandom, ax, ay, az, bx, by, bz);
        end
      endcase
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_degenerate();
    test_extremes();
    test_near_parallel();
    test_random(450);
    s_tvalid <= 1'b0;
    while (frames_pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && frames_pending.size() == 0) begin
      $display("orthonormal_frame_from_points_core: match");
    end else begin
      $display("orthonormal_frame_from_points_core: mismatch");
    end
    $finish;
  end
endmodule

>>> orthonormal_frame_from_points_core.f
+incdir+sv
sv/ofp_pkg.sv
sv/ofp_delay.sv
sv/ofp_bscale.sv
sv/ofp_isqrt.sv
sv/ofp_div.sv
sv/ofp_unit.sv
sv/ofp_out_buf.sv
sv/orthonormal_frame_from_points_core.sv
tb/testbench.sv
